>>> rtl/ffa_pkg.sv
// Shared constants, codes and types of the first-fit free-region allocator.
package ffa_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        t_addr start;
        t_addr size;
    } t_entry;

    typedef struct packed {
        logic  fits;
        logic  exact;
        logic  contains;
        t_addr new_start;
        t_addr new_size;
    } t_alu_res;

endpackage

>>> rtl/ffa_table.sv
// Region table memory: one write port and one registered read port.
module ffa_table (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  ffa_pkg::t_idx   i_wr_idx,
    input  ffa_pkg::t_entry i_wr_data,
    input  ffa_pkg::t_idx   i_rd_idx,
    output ffa_pkg::t_entry o_rd_data
);
    import ffa_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/ffa_alu.sv
// Shared compare and update unit applied to one table entry at a time.
module ffa_alu (
    input  ffa_pkg::t_entry   i_entry,
    input  ffa_pkg::t_addr    i_req_size,
    input  ffa_pkg::t_addr    i_probe,
    output ffa_pkg::t_alu_res o_res
);
    import ffa_pkg::*;

    t_addr w_offset;

    // The offset is only meaningful when the probe is at or above the start.
    assign w_offset = i_probe - i_entry.start;

    always_comb begin
        o_res.fits      = (i_entry.size >= i_req_size);
        o_res.exact     = (i_entry.size == i_req_size);
        o_res.contains  = (i_probe >= i_entry.start) && (w_offset < i_entry.size);
        o_res.new_start = i_entry.start + i_req_size;
        o_res.new_size  = i_entry.size - i_req_size;
    end

endmodule

>>> rtl/first_fit_free_list_allocator.sv
// Sequence: an add writes its entry on acceptance; allocate and query scan the table entry by entry,
// each entry passing through S_READ and S_CHECK, until the first match or the end of the table.
// A removal on an exact fit moves every later entry up one place through S_SH_RD and S_SH_WR.
// One item at a time: a new item is taken only once the previous result is queued.
// Reset clears the sequencer, the region count, the scan index and the output valid flag; the table is not cleared.
module first_fit_free_list_allocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  ffa_pkg::t_addr        i_address,
    input  ffa_pkg::t_addr        i_size,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffa_pkg::t_addr        o_result_address,
    output logic                  o_hit,
    output logic                  o_table_full
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state   r_state;
    t_cnt     r_count;
    t_cnt     r_idx;
    logic [1:0] r_action;
    t_addr    r_addr;
    t_addr    r_size;
    t_addr    r_res_addr;
    logic     r_hit;
    logic     r_full;
    logic     r_out_valid;
    t_addr    r_o_addr;
    logic     r_o_hit;
    logic     r_o_full;

    logic     w_accept;
    logic     w_wr_en;
    t_idx     w_wr_idx;
    t_entry   w_wr_data;
    t_idx     w_rd_idx;
    t_entry   w_rd_data;
    t_alu_res w_alu;
    t_cnt     w_idx_next;
    logic     w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_idx_next  = r_idx + t_cnt'(1);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Read the entry being scanned, or the next one while closing a gap.
    assign w_rd_idx = (r_state == S_SH_RD) ? w_idx_next[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_idx  = r_idx[IDX_W-1:0];
        w_wr_data = w_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_action == ACT_ADD && r_count < t_cnt'(TABLE_DEPTH)) begin
                    w_wr_en         = 1'b1;
                    w_wr_idx        = r_count[IDX_W-1:0];
                    w_wr_data.start = i_address;
                    w_wr_data.size  = i_size;
                end
            end
            S_CHECK: begin
                if (r_action == ACT_ALLOC && w_alu.fits && !w_alu.exact) begin
                    w_wr_en         = 1'b1;
                    w_wr_data.start = w_alu.new_start;
                    w_wr_data.size  = w_alu.new_size;
                end
            end
            S_SH_WR: begin
                w_wr_en = 1'b1;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    ffa_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (w_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data)
    );

    ffa_alu u_alu (
        .i_entry    (w_rd_data),
        .i_req_size (r_size),
        .i_probe    (r_addr),
        .o_res      (w_alu)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_action   <= i_action;
                        r_addr     <= i_address;
                        r_size     <= i_size;
                        r_idx      <= '0;
                        r_res_addr <= '0;
                        r_hit      <= 1'b0;
                        r_full     <= 1'b0;
                        if (i_action == ACT_ALLOC || i_action == ACT_QUERY) begin
                            r_state <= S_READ;
                        end else begin
                            if (i_action == ACT_ADD) begin
                                if (r_count < t_cnt'(TABLE_DEPTH)) begin
                                    r_count <= r_count + t_cnt'(1);
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx < r_count) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CHECK: begin
                    if (r_action == ACT_ALLOC) begin
                        if (w_alu.fits) begin
                            r_res_addr <= w_rd_data.start;
                            r_hit      <= 1'b1;
                            r_state    <= w_alu.exact ? S_SH_RD : S_DONE;
                        end else begin
                            r_idx   <= w_idx_next;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (w_alu.contains) begin
                            r_hit   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= w_idx_next;
                            r_state <= S_READ;
                        end
                    end
                end
                S_SH_RD: begin
                    // Later entries move up one place until the end of the table.
                    if (w_idx_next < r_count) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_count <= r_count - t_cnt'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= w_idx_next;
                    r_state <= S_SH_RD;
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_o_addr    <= r_res_addr;
                        r_o_hit     <= r_hit;
                        r_o_full    <= r_full;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_o_addr;
    assign o_hit            = r_o_hit;
    assign o_table_full     = r_o_full;

endmodule

>>> tb/first_fit_free_list_allocator_tb.sv
// Self-checking testbench of the first-fit free-region allocator.
module first_fit_free_list_allocator_tb;
    import ffa_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam t_addr ADDR_MAX = '1;
    localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 8;

    typedef struct packed {
        t_addr result_address;
        logic  hit;
        logic  table_full;
    } t_reply;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_action = '0;
    t_addr      i_address = '0;
    t_addr      i_size = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_addr      o_result_address;
    logic       o_hit;
    logic       o_table_full;

    // Free list as the block should hold it.
    t_addr free_start [TABLE_DEPTH];
    t_addr free_size [TABLE_DEPTH];
    int    free_count = 0;

    t_reply awaited_replies [$];
    int     error_count = 0;
    bit     idle_enable = 1'b1;
    int     ready_hold_request = 0;

    int adds_seen = 0, adds_dropped = 0;
    int allocs_seen = 0, allocs_found = 0;
    int queries_seen = 0, queries_found = 0;

    first_fit_free_list_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_address        (i_address),
        .i_size           (i_size),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_address (o_result_address),
        .o_hit            (o_hit),
        .o_table_full     (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    // Applies one item to the free list and returns the reply it should produce.
    function automatic t_reply compute_region_reply(input logic [1:0] act, input t_addr addr,
                                                    input t_addr size);
        t_reply r;
        bit     found;
        r = '0;
        found = 1'b0;
        case (act)
            ACT_ADD: begin
                if (free_count < TABLE_DEPTH) begin
                    free_start[free_count] = addr;
                    free_size[free_count] = size;
                    free_count++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            ACT_ALLOC: begin
                for (int k = 0; k < free_count && !found; k++) begin
                    if (free_size[k] >= size) begin
                        found = 1'b1;
                        r.result_address = free_start[k];
                        r.hit = 1'b1;
                        if (free_size[k] == size) begin
                            for (int j = k; j + 1 < free_count; j++) begin
                                free_start[j] = free_start[j + 1];
                                free_size[j] = free_size[j + 1];
                            end
                            free_count--;
                        end else begin
                            free_start[k] = free_start[k] + size;
                            free_size[k] = free_size[k] - size;
                        end
                    end
                end
            end
            ACT_QUERY: begin
                for (int k = 0; k < free_count; k++)
                    if (addr >= free_start[k] && addr - free_start[k] < free_size[k])
                        r.hit = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_addr rand_address();
        if ($urandom_range(7) == 0)
            return ADDR_MAX - t_addr'($urandom_range(4096));
        return t_addr'({$urandom, $urandom});
    endfunction

    // Mostly modest sizes, with the odd zero and full-width value.
    function automatic t_addr rand_size();
        case ($urandom_range(9))
            0: return '0;
            1, 2: return t_addr'({$urandom, $urandom});
            default: return t_addr'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input t_addr addr, input t_addr size);
        t_reply want;
        if (idle_enable)
            while ($urandom_range(99) < 7) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_address  <= addr;
        i_size     <= size;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        want = compute_region_reply(act, addr, size);
        awaited_replies.push_back(want);
        case (act)
            ACT_ADD: begin
                adds_seen++;
                adds_dropped += want.table_full;
            end
            ACT_ALLOC: begin
                allocs_seen++;
                allocs_found += want.hit;
            end
            ACT_QUERY: begin
                queries_seen++;
                queries_found += want.hit;
            end
            default: ;
        endcase
    endtask

    // Builds an item from the current free list so that most allocations and
    // queries land on or next to a real region.
    task automatic send_random_item(output bit counted);
        int    pick;
        int    k;
        t_addr addr;
        t_addr size;
        pick = $urandom_range(99);
        k = (free_count > 0) ? $urandom_range(free_count - 1) : 0;
        counted = 1'b1;
        if (pick < 35) begin
            send_item(ACT_ADD, rand_address(), rand_size());
        end else if (pick < 70) begin
            if (free_count == 0)
                size = rand_size();
            else
                case ($urandom_range(5))
                    0: size = free_size[k];
                    1: size = free_size[k] >> 1;
                    2: size = '0;
                    3: size = rand_size();
                    default: size = free_size[k] + 1;
                endcase
            send_item(ACT_ALLOC, rand_address(), size);
        end else if (pick < 97) begin
            if (free_count == 0)
                addr = rand_address();
            else
                case ($urandom_range(5))
                    0: addr = free_start[k];
                    1: addr = free_start[k] + free_size[k] - 1;
                    2: addr = free_start[k] + free_size[k];
                    3: addr = free_start[k] - 1;
                    4: addr = free_start[k] + t_addr'($urandom_range(64));
                    default: addr = rand_address();
                endcase
            send_item(ACT_QUERY, addr, rand_size());
        end else begin
            send_item(ACT_UNUSED, rand_address(), rand_size());
            counted = 1'b0;
        end
    endtask

    task automatic send_random_items(input int count);
        int sent;
        bit counted;
        sent = 0;
        while (sent < count) begin
            send_random_item(counted);
            sent += counted;
        end
    endtask

    task automatic test_edge_cases();
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_UNUSED, ADDR_MAX, ADDR_MAX);
        // A region that runs past the top of the address space does not wrap.
        send_item(ACT_ADD, ADDR_MAX, ADDR_MAX);
        send_item(ACT_QUERY, ADDR_MAX, '0);
        send_item(ACT_QUERY, '0, ADDR_MAX);
        send_item(ACT_ADD, t_addr'(48'h1000), '0);
        send_item(ACT_QUERY, t_addr'(48'h1000), '0);
        send_item(ACT_ALLOC, '0, '0);
        // Shrinking the top region by one wraps its start round to zero.
        send_item(ACT_ALLOC, ADDR_MAX, t_addr'(1));
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_ALLOC, '0, ADDR_MAX - 1);
        // The empty region now at the head is taken by a zero-size request.
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_ALLOC, '0, t_addr'(1));
        send_item(ACT_ADD, t_addr'(48'h5555_5555_5555), t_addr'(48'hAAAA_AAAA_AAAA));
        send_item(ACT_ALLOC, '0, ADDR_MAX);
        send_item(ACT_QUERY, t_addr'(48'hFFFF_FFFF_FFFE), '0);
        send_item(ACT_QUERY, t_addr'(48'hFFFF_FFFF_FFFF), '0);
        send_item(ACT_ALLOC, '0, t_addr'(48'hAAAA_AAAA_AAAA));
    endtask

    task automatic test_table_full();
        while (free_count < TABLE_DEPTH)
            send_item(ACT_ADD, rand_address(), t_addr'($urandom_range(1, 64)));
        repeat (2) send_item(ACT_ADD, rand_address(), rand_size());
        send_item(ACT_QUERY, free_start[TABLE_DEPTH - 1], '0);
        // An exact fit at the head moves every later entry up one place.
        send_item(ACT_ALLOC, '0, free_size[0]);
        send_item(ACT_ADD, rand_address(), rand_size());
        send_item(ACT_ADD, rand_address(), rand_size());
        send_item(ACT_ALLOC, '0, ADDR_MAX);
    endtask

    task automatic test_output_backpressure();
        ready_hold_request = 400;
        send_random_items(24);
    endtask

    task automatic test_steady_stream();
        idle_enable = 1'b0;
        send_random_items(200);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_traffic();
        send_random_items(800);
    endtask

    initial begin : reply_checker
        t_reply want;
        int     hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (awaited_replies.size() == 0) begin
                    $error("result item arrived with nothing outstanding");
                    error_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (o_result_address !== want.result_address) begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, o_result_address);
                        error_count++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %b, got %b", want.hit, o_hit);
                        error_count++;
                    end
                    if (o_table_full !== want.table_full) begin
                        $error("table_full: expected %b, got %b",
                               want.table_full, o_table_full);
                        error_count++;
                    end
                end
            end
            if (ready_hold_request != 0) begin
                hold_left = ready_hold_request;
                ready_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_enable || ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_table_full();
        test_output_backpressure();
        test_steady_stream();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d adds (%0d dropped on a full list) and %0d allocations (%0d found).",
                 adds_seen, adds_dropped, allocs_seen, allocs_found);
        $display("Covered %0d address queries, %0d of them inside a free region.",
                 queries_seen, queries_found);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
